@@ rtl/core/scrqe_pkg.sv @@
package scrqe_pkg;

  localparam int unsigned EntryDepth = 1024;
  localparam int unsigned IdxW       = 16;
  localparam int unsigned AddrW      = $clog2(EntryDepth);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned ValW       = 32;
  localparam int unsigned HgtW       = IdxW + 1;
  localparam int unsigned ResW       = 64;
  // Room for every pair product counted twice plus both square sums.
  localparam int unsigned AccW       = ResW + 2 * CntW + 2;
  localparam int unsigned EntW       = 2 * IdxW + ValW;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_GET    = 3'd1,
    OP_DOT    = 3'd2,
    OP_DIST   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    K_SQ   = 2'd0,
    K_PAIR = 2'd1,
    K_GET  = 2'd2
  } kind_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_NEXT  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_OUTER = 7'b0001000,
    S_OUTW  = 7'b0010000,
    S_INNER = 7'b0100000,
    S_DRAIN = 7'b1000000
  } state_e;

endpackage

@@ rtl/core/sparse_coo_row_query_engine.sv @@
// Channel   Direction  Ports                                                  Beat taken
// command   in         start, busy, opcode_i, column_index_i, row_index_i,    start && !busy
//                      second_row_index_i, entry_value_i
// result    out        done_o, result_value_o, status_o, entry_count_o,       every done_o cycle
//                      row_count_o
//
// Insert, clear and unused opcodes finish in the cycle of acceptance; their result
// beat shows in the next cycle and busy never rises, so they can follow back to back.
// Get makes one scan of all stored entries. Dot product and distance make an outer scan
// of all entries plus an inner scan of all entries for each entry of the first row, a
// scan per square and a drain; the single read port of the memory sets this.
// Reset clears the entry count and the height; memory contents need no clearing.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module sparse_coo_row_query_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    opcode_i,
  input  logic [scrqe_pkg::IdxW-1:0]    column_index_i,
  input  logic [scrqe_pkg::IdxW-1:0]    row_index_i,
  input  logic [scrqe_pkg::IdxW-1:0]    second_row_index_i,
  input  logic signed [scrqe_pkg::ValW-1:0] entry_value_i,
  output logic                          done_o,
  output logic signed [scrqe_pkg::ResW-1:0] result_value_o,
  output logic [1:0]                    status_o,
  output logic [scrqe_pkg::CntW-1:0]    entry_count_o,
  output logic [scrqe_pkg::HgtW-1:0]    row_count_o
);
  import scrqe_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [HgtW-1:0] height_q, height_d;
  logic need_get_q, need_get_d, need_sq1_q, need_sq1_d;
  logic need_sq2_q, need_sq2_d, need_pair_q, need_pair_d;
  logic rd_v_q, rd_v_d, prod_v_q, done_q, done_d;
  logic found_q, found_d;

  logic [IdxW-1:0] r1_q, r2_q, col_q, tgt_q, tgt_d, coli_q, coli_d;
  logic [ValW-1:0] vali_q, vali_d, getval_q, getval_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  kind_e kind_q, kind_d, rd_kind_q, rd_kind_d;
  logic [2:0] op_q;
  logic signed [ResW-1:0] prod_q, res_q, res_d;
  logic prod_neg_q;
  logic signed [AccW-1:0] acc_q, prod_ext;
  logic [1:0] status_q, status_d;

  logic accept;
  logic we;
  logic [AddrW-1:0] raddr;
  logic [EntW-1:0] rdata;
  logic [IdxW-1:0] rd_col, rd_row, match_row;
  logic signed [ValW-1:0] rd_val, mul_a;
  logic match;
  logic [HgtW-1:0] row_p1, r1_h, r2_h;
  logic signed [ResW-1:0] sat;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign rd_col = rdata[EntW-1 -: IdxW];
  assign rd_row = rdata[ValW +: IdxW];
  assign rd_val = signed'(rdata[ValW-1:0]);
  assign row_p1 = {1'b0, row_index_i} + HgtW'(1);
  assign r1_h   = {1'b0, row_index_i};
  assign r2_h   = {1'b0, second_row_index_i};

  // The memory holds {column, row, value} for each stored entry.
  assign we = accept && (op_e'(opcode_i) == OP_INSERT) && (status_d == ST_OK);

  scrqe_ram #(.Width(EntW), .Depth(EntryDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i ({column_index_i, row_index_i, entry_value_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer: scans for squares and lookups, and a nested scan for row pairs.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    height_d = height_q;
    need_get_d = need_get_q;
    need_sq1_d = need_sq1_q;
    need_sq2_d = need_sq2_q;
    need_pair_d = need_pair_q;
    kind_d = kind_q;
    tgt_d = tgt_q;
    i_d = i_q;
    j_d = j_q;
    coli_d = coli_q;
    vali_d = vali_q;
    rd_v_d = 1'b0;
    rd_kind_d = kind_q;
    raddr = j_q[AddrW-1:0];
    done_d = 1'b0;
    res_d = res_q;
    status_d = ST_OK;

    if (accept) begin
      case (op_e'(opcode_i))
        OP_INSERT: begin
          if (count_q == CntW'(EntryDepth)) begin
            status_d = ST_FULL;
          end else if (height_q != '0 && row_p1 < height_q) begin
            status_d = ST_ORDER;
          end else begin
            count_d = count_q + CntW'(1);
            if (row_p1 > height_q) begin
              height_d = row_p1;
            end
          end
        end
        OP_CLEAR: begin
          count_d = '0;
          height_d = '0;
        end
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          need_get_d = 1'b0;
          need_sq1_d = 1'b0;
          need_sq2_d = 1'b0;
          need_pair_d = 1'b0;
          case (op_e'(opcode_i))
            OP_GET: begin
              need_get_d = 1'b1;
              state_d = S_NEXT;
            end
            OP_DOT: begin
              need_pair_d = (r1_h < height_q) && (r2_h < height_q);
              state_d = S_NEXT;
            end
            OP_DIST: begin
              if (row_index_i != second_row_index_i) begin
                need_sq1_d = r1_h < height_q;
                need_sq2_d = r2_h < height_q;
                need_pair_d = (r1_h < height_q) && (r2_h < height_q);
              end
              state_d = S_NEXT;
            end
            default: begin
              res_d = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_NEXT: begin
        j_d = '0;
        i_d = '0;
        if (need_get_q) begin
          need_get_d = 1'b0;
          kind_d = K_GET;
          state_d = S_SCAN;
        end else if (need_sq1_q) begin
          need_sq1_d = 1'b0;
          kind_d = K_SQ;
          tgt_d = r1_q;
          state_d = S_SCAN;
        end else if (need_sq2_q) begin
          need_sq2_d = 1'b0;
          kind_d = K_SQ;
          tgt_d = r2_q;
          state_d = S_SCAN;
        end else if (need_pair_q) begin
          need_pair_d = 1'b0;
          kind_d = K_PAIR;
          state_d = S_OUTER;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_SCAN: begin
        if (j_q == count_q) begin
          state_d = S_NEXT;
        end else begin
          rd_v_d = 1'b1;
          j_d = j_q + CntW'(1);
        end
      end
      S_OUTER: begin
        raddr = i_q[AddrW-1:0];
        if (i_q == count_q) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_OUTW;
        end
      end
      S_OUTW: begin
        if (rd_row == r1_q) begin
          coli_d = rd_col;
          vali_d = rdata[ValW-1:0];
          j_d = '0;
          state_d = S_INNER;
        end else begin
          i_d = i_q + CntW'(1);
          state_d = S_OUTER;
        end
      end
      S_INNER: begin
        if (j_q == count_q) begin
          i_d = i_q + CntW'(1);
          state_d = S_OUTER;
        end else begin
          rd_v_d = 1'b1;
          j_d = j_q + CntW'(1);
        end
      end
      S_DRAIN: begin
        if (!rd_v_q && !prod_v_q) begin
          if (op_e'(op_q) == OP_GET) begin
            res_d = found_q ? ResW'(signed'(getval_q)) : '0;
          end else begin
            res_d = sat;
          end
          done_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Data return stage: match the entry read last cycle.
  always_comb begin
    match_row = (rd_kind_q == K_PAIR) ? r2_q : (rd_kind_q == K_SQ) ? tgt_q : r1_q;
    match = rd_v_q && (rd_row == match_row) &&
            ((rd_kind_q == K_SQ) || (rd_col == ((rd_kind_q == K_PAIR) ? coli_q : col_q)));
    mul_a = (rd_kind_q == K_PAIR) ? signed'(vali_q) : rd_val;
    found_d = found_q;
    getval_d = getval_q;
    if (match && rd_kind_q == K_GET && !found_q) begin
      found_d = 1'b1;
      getval_d = rdata[ValW-1:0];
    end
  end

  assign prod_ext = AccW'(prod_q);

  // Saturate the wide sum to 64 bits.
  always_comb begin
    if (acc_q[AccW-1:ResW-1] == '0 || acc_q[AccW-1:ResW-1] == '1) begin
      sat = acc_q[ResW-1:0];
    end else if (acc_q[AccW-1]) begin
      sat = {1'b1, {(ResW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(ResW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      height_q <= '0;
      need_get_q <= 1'b0;
      need_sq1_q <= 1'b0;
      need_sq2_q <= 1'b0;
      need_pair_q <= 1'b0;
      rd_v_q <= 1'b0;
      prod_v_q <= 1'b0;
      done_q <= 1'b0;
      found_q <= 1'b0;
      kind_q <= K_SQ;
      rd_kind_q <= K_SQ;
      i_q <= '0;
      j_q <= '0;
      res_q <= '0;
      status_q <= ST_OK;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      height_q <= height_d;
      need_get_q <= need_get_d;
      need_sq1_q <= need_sq1_d;
      need_sq2_q <= need_sq2_d;
      need_pair_q <= need_pair_d;
      rd_v_q <= rd_v_d;
      prod_v_q <= match && (rd_kind_q != K_GET);
      done_q <= done_d;
      found_q <= accept ? 1'b0 : found_d;
      kind_q <= kind_d;
      rd_kind_q <= rd_kind_d;
      i_q <= i_d;
      j_q <= j_d;
      if (done_d) begin
        res_q <= res_d;
      end
      if (accept) begin
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
    coli_q <= coli_d;
    vali_q <= vali_d;
    getval_q <= getval_d;
    prod_q <= mul_a * rd_val;
    prod_neg_q <= (rd_kind_q == K_PAIR) && (op_e'(op_q) == OP_DIST);
    if (accept) begin
      r1_q <= row_index_i;
      r2_q <= second_row_index_i;
      col_q <= column_index_i;
      op_q <= opcode_i;
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= prod_neg_q ? acc_q - (prod_ext <<< 1) : acc_q + prod_ext;
    end
  end

  assign done_o = done_q;
  assign result_value_o = res_q;
  assign status_o = status_q;
  assign entry_count_o = count_q;
  assign row_count_o = height_q;

endmodule

@@ rtl/core/scrqe_ram.sv @@
module scrqe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/scrqe_checker.sv @@
module scrqe_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic [1:0]                 status_o,
  input logic [scrqe_pkg::CntW-1:0] entry_count_o
);
  import scrqe_pkg::*;

  // Every accepted command either finishes at once or keeps the block busy.
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted command neither finished nor busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_FULL || status_o == ST_ORDER))
    else $error("illegal status code");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (entry_count_o == CntW'(EntryDepth)))
    else $error("full status while store not full");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> $stable(entry_count_o))
    else $error("dropped insert changed the entry count");

endmodule

bind sparse_coo_row_query_engine scrqe_checker u_scrqe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .entry_count_o (entry_count_o)
);
